>>> src/dsib_pkg.sv
// ---------------------------------------------------------------------------
// dsib_pkg
// Shared types and constants of the sorted index builder.
// ---------------------------------------------------------------------------
package dsib_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int WORD_W      = 32;
    localparam int SRC_W       = 4;

    localparam logic [WORD_W-1:0] SIGN_FLIP = {1'b1, {(WORD_W-1){1'b0}}};

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_READ   = 2'd1,
        ACT_CLEAR  = 2'd2,
        ACT_NONE   = 2'd3
    } t_action;

    typedef enum logic [3:0] {
        STAT_ADDED     = 4'd0,
        STAT_DUP       = 4'd1,
        STAT_CONFLICT  = 4'd2,
        STAT_ZERO      = 4'd3,
        STAT_FULL      = 4'd4,
        STAT_IGNORED   = 4'd5,
        STAT_READ_OK   = 4'd6,
        STAT_RANK_BAD  = 4'd7,
        STAT_CLEARED   = 4'd8
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_APPLY
    } t_state;

    typedef struct packed {
        logic [WORD_W-1:0] key;
        logic [WORD_W-1:0] size;
        logic [WORD_W-1:0] offset;
        logic [SRC_W-1:0]  snum;
        logic [WORD_W-1:0] soff;
    } t_entry;

    typedef struct packed {
        logic cmp_en;
        logic shift_en;
    } t_cell_ctl;

    typedef struct packed {
        logic any_eq;
        logic any_same;
    } t_match;

endpackage

>>> src/dsib_cell.sv
// ---------------------------------------------------------------------------
// dsib_cell
// One slot of the sorted chain: holds an entry, compares it with the new
// entry and on insertion shifts in its left neighbor's entry or the new one.
// ---------------------------------------------------------------------------
module dsib_cell import dsib_pkg::*; (
    input  logic             i_clk,
    input  t_cell_ctl        i_ctl,
    input  logic             i_valid,
    input  logic [IDX_W-1:0] i_index,
    input  logic [IDX_W-1:0] i_rank,
    input  t_entry           i_new,
    input  t_entry           i_left,
    input  logic             i_left_lt,
    output t_entry           o_entry,
    output logic             o_lt,
    output logic             o_eq,
    output logic             o_same,
    output logic             o_sel
);

    t_entry r_entry;
    logic   r_lt;
    logic   r_eq;
    logic   r_same;
    logic   r_sel;
    logic   n_lt;
    logic   n_eq;

    always_comb begin
        n_lt = i_valid && ((r_entry.key ^ SIGN_FLIP) < (i_new.key ^ SIGN_FLIP));
        n_eq = i_valid && (r_entry.key == i_new.key);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.cmp_en) begin
            r_lt   <= n_lt;
            r_eq   <= n_eq;
            r_same <= n_eq && (r_entry.size == i_new.size);
            r_sel  <= i_valid && (i_index == i_rank);
        end
        if (i_ctl.shift_en) begin
            if (!i_left_lt) begin
                r_entry <= i_left;
            end else if (!r_lt) begin
                r_entry <= i_new;
            end
        end
    end

    assign o_entry = r_entry;
    assign o_lt    = r_lt;
    assign o_eq    = r_eq;
    assign o_same  = r_same;
    assign o_sel   = r_sel;

endmodule

>>> src/dsib_ctrl.sv
// ---------------------------------------------------------------------------
// dsib_ctrl
// Sequencer, totals and result register of the sorted index builder.
// ---------------------------------------------------------------------------
module dsib_ctrl import dsib_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [1:0]        i_action,
    input  logic [WORD_W-1:0] i_entry_key,
    input  logic [WORD_W-1:0] i_entry_size,
    input  logic [WORD_W-1:0] i_source_offset,
    input  logic [SRC_W-1:0]  i_source_number,
    input  logic [IDX_W-1:0]  i_read_rank,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [3:0]        o_status,
    output t_entry            o_read,
    output logic [CNT_W-1:0]  o_entry_total,
    output logic [WORD_W-1:0] o_body_total,
    output logic              o_merge_failed,
    output t_cell_ctl         o_ctl,
    output t_entry            o_new,
    output logic [IDX_W-1:0]  o_rank,
    output logic [CNT_W-1:0]  o_count,
    input  t_match            i_match,
    input  t_entry            i_rd
);

    t_state            r_state;
    t_state            n_state;
    logic [1:0]        r_action;
    t_entry            r_item;
    logic [IDX_W-1:0]  r_rank;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic [WORD_W-1:0] r_total;
    logic [WORD_W-1:0] n_total;
    logic              r_failed;
    logic              n_failed;
    t_status           n_status;
    logic              n_add;
    logic              r_out_valid;
    t_status           r_out_status;
    t_entry            r_out_read;
    logic              w_go;

    assign w_go = !r_out_valid || i_ready;

    always_comb begin
        n_count  = r_count;
        n_total  = r_total;
        n_failed = r_failed;
        n_add    = 1'b0;
        n_status = STAT_IGNORED;
        case (t_action'(r_action))
            ACT_INSERT: begin
                if (r_failed) begin
                    n_status = STAT_IGNORED;
                end else if (r_item.size == '0) begin
                    n_status = STAT_ZERO;
                end else if (i_match.any_eq) begin
                    if (i_match.any_same) begin
                        n_status = STAT_DUP;
                    end else begin
                        n_status = STAT_CONFLICT;
                        n_failed = 1'b1;
                    end
                end else if (r_count >= CNT_W'(TABLE_DEPTH)) begin
                    n_status = STAT_FULL;
                    n_failed = 1'b1;
                end else begin
                    n_status = STAT_ADDED;
                    n_add    = 1'b1;
                    n_count  = r_count + 1'b1;
                    n_total  = r_total + r_item.size;
                end
            end
            ACT_READ: begin
                if ({1'b0, r_rank} < r_count) begin
                    n_status = STAT_READ_OK;
                end else begin
                    n_status = STAT_RANK_BAD;
                end
            end
            ACT_CLEAR: begin
                n_status = STAT_CLEARED;
                n_count  = '0;
                n_total  = '0;
                n_failed = 1'b0;
            end
            default: begin
                n_status = STAT_IGNORED;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                n_state = S_APPLY;
            end
            S_APPLY: begin
                if (w_go) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_ready         = (r_state == S_IDLE);
        o_ctl.cmp_en    = (r_state == S_CMP);
        o_ctl.shift_en  = (r_state == S_APPLY) && w_go && n_add;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_total     <= '0;
            r_failed    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == S_APPLY && w_go) begin
                r_count     <= n_count;
                r_total     <= n_total;
                r_failed    <= n_failed;
                r_out_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_valid) begin
            r_action      <= i_action;
            r_item.key    <= i_entry_key;
            r_item.size   <= i_entry_size;
            r_item.offset <= r_total;
            r_item.soff   <= i_source_offset;
            r_item.snum   <= i_source_number;
            r_rank        <= i_read_rank;
        end
        if (r_state == S_APPLY && w_go) begin
            r_out_status <= n_status;
            r_out_read   <= (n_status == STAT_READ_OK) ? i_rd : '0;
        end
    end

    assign o_new          = r_item;
    assign o_rank         = r_rank;
    assign o_count        = r_count;
    assign o_valid        = r_out_valid;
    assign o_status       = r_out_status;
    assign o_read         = r_out_read;
    assign o_entry_total  = r_count;
    assign o_body_total   = r_total;
    assign o_merge_failed = r_failed;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(TABLE_DEPTH))
        else $error("held entry count beyond table depth");

    a_shift_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> !o_ctl.shift_en && !o_ctl.cmp_en)
        else $error("cell row active while accepting a transaction");

    a_add_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.shift_en |=> r_count == $past(r_count) + 1'b1)
        else $error("insertion did not grow the entry count");

    a_fail_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_failed) |-> (o_status == STAT_CONFLICT || o_status == STAT_FULL))
        else $error("failure flag set without conflict or full status");

endmodule

>>> src/dedup_sorted_index_builder.sv
// ---------------------------------------------------------------------------
// dedup_sorted_index_builder
// Merged archive index kept sorted by signed key in a row of cells.
// ---------------------------------------------------------------------------
// Each transaction is captured in S_IDLE on acceptance. In S_CMP every
// cell of the 256-entry row compares its entry with the new key or the
// read rank. In S_APPLY the matches are combined, the row shifts to open
// the insertion slot and the result is registered; S_APPLY holds while an
// earlier result waits on the output. A new transaction is accepted once
// the previous one has left S_APPLY, even while its result still waits on
// the output. No clearing pass follows reset; the table is usable at once.
module dedup_sorted_index_builder import dsib_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [1:0]        i_action,
    input  logic [WORD_W-1:0] i_entry_key,
    input  logic [WORD_W-1:0] i_entry_size,
    input  logic [WORD_W-1:0] i_source_offset,
    input  logic [SRC_W-1:0]  i_source_number,
    input  logic [IDX_W-1:0]  i_read_rank,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [3:0]        o_status,
    output logic [WORD_W-1:0] o_out_key,
    output logic [WORD_W-1:0] o_out_offset,
    output logic [WORD_W-1:0] o_out_size,
    output logic [SRC_W-1:0]  o_out_source_number,
    output logic [WORD_W-1:0] o_out_source_offset,
    output logic [CNT_W-1:0]  o_entry_total,
    output logic [WORD_W-1:0] o_body_total,
    output logic              o_merge_failed
);

    t_cell_ctl        w_ctl;
    t_entry           w_new;
    logic [IDX_W-1:0] w_rank;
    logic [CNT_W-1:0] w_count;
    t_match           w_match;
    t_entry           w_rd;
    t_entry           w_read;
    t_entry           w_entry [TABLE_DEPTH];
    logic             w_lt    [TABLE_DEPTH];
    logic             w_eq    [TABLE_DEPTH];
    logic             w_same  [TABLE_DEPTH];
    logic             w_sel   [TABLE_DEPTH];

    dsib_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_action        (i_action),
        .i_entry_key     (i_entry_key),
        .i_entry_size    (i_entry_size),
        .i_source_offset (i_source_offset),
        .i_source_number (i_source_number),
        .i_read_rank     (i_read_rank),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_status        (o_status),
        .o_read          (w_read),
        .o_entry_total   (o_entry_total),
        .o_body_total    (o_body_total),
        .o_merge_failed  (o_merge_failed),
        .o_ctl           (w_ctl),
        .o_new           (w_new),
        .o_rank          (w_rank),
        .o_count         (w_count),
        .i_match         (w_match),
        .i_rd            (w_rd)
    );

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        logic   w_valid;
        t_entry w_left;
        logic   w_left_lt;

        assign w_valid = (CNT_W'(g) < w_count);

        if (g == 0) begin : g_head
            assign w_left    = w_new;
            assign w_left_lt = 1'b1;
        end else begin : g_body
            assign w_left    = w_entry[g-1];
            assign w_left_lt = w_lt[g-1];
        end

        dsib_cell u_cell (
            .i_clk     (i_clk),
            .i_ctl     (w_ctl),
            .i_valid   (w_valid),
            .i_index   (IDX_W'(g)),
            .i_rank    (w_rank),
            .i_new     (w_new),
            .i_left    (w_left),
            .i_left_lt (w_left_lt),
            .o_entry   (w_entry[g]),
            .o_lt      (w_lt[g]),
            .o_eq      (w_eq[g]),
            .o_same    (w_same[g]),
            .o_sel     (w_sel[g])
        );
    end

    always_comb begin
        w_match.any_eq   = 1'b0;
        w_match.any_same = 1'b0;
        w_rd             = '0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            w_match.any_eq   = w_match.any_eq | w_eq[i];
            w_match.any_same = w_match.any_same | w_same[i];
            if (w_sel[i]) begin
                w_rd = t_entry'(w_rd | w_entry[i]);
            end
        end
    end

    assign o_out_key           = w_read.key;
    assign o_out_offset        = w_read.offset;
    assign o_out_size          = w_read.size;
    assign o_out_source_number = w_read.snum;
    assign o_out_source_offset = w_read.soff;

endmodule

>>> dv/dedup_sorted_index_builder_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dedup_sorted_index_builder_tb
// Self-checking bench for the merged archive index builder. A short table of
// directed transactions covers the key and size extremes, duplicates,
// conflicts, the ignore state after failure, reads out of range and clear.
// A fill phase drives the table to full and past it. Random merges follow.
// Each result is checked against its directed row or a predictor that keeps
// its own sorted table. Both handshakes idle in random bursts until CALM_FROM.
// ---------------------------------------------------------------------------
module dedup_sorted_index_builder_tb;
    import dsib_pkg::*;

    localparam int ITEM_GOAL    = 650;
    localparam int CALM_FROM    = 600;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 12;
    localparam int NUM_DIRECTED = 24;

    typedef struct packed {
        t_action           act;
        logic [WORD_W-1:0] key;
        logic [WORD_W-1:0] size;
        logic [WORD_W-1:0] soff;
        logic [SRC_W-1:0]  snum;
        logic [IDX_W-1:0]  rank;
    } t_req;

    typedef struct packed {
        t_status           status;
        t_entry            ent;
        logic [CNT_W-1:0]  count;
        logic [WORD_W-1:0] body;
        logic              failed;
    } t_result;

    typedef struct packed {
        t_req              req;
        logic              typed;
        t_status           st;
        logic [CNT_W-1:0]  cnt;
        logic [WORD_W-1:0] body;
        logic              bad;
    } t_row;

    localparam t_row DIRECTED_ROWS [NUM_DIRECTED] = '{
        '{'{ACT_READ,   32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 4'h0, 8'd0},
          1'b1, STAT_RANK_BAD, 9'd0, 32'h0000_0000, 1'b0},
        '{'{ACT_INSERT, 32'h1234_5678, 32'h0000_0000, 32'hFFFF_FFFF, 4'hF, 8'd0},
          1'b1, STAT_ZERO, 9'd0, 32'h0000_0000, 1'b0},
        '{'{ACT_INSERT, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hF, 8'd255},
          1'b1, STAT_ADDED, 9'd1, 32'hFFFF_FFFF, 1'b0},
        '{'{ACT_INSERT, 32'h7FFF_FFFF, 32'h0000_0002, 32'h0000_0000, 4'h0, 8'd0},
          1'b1, STAT_ADDED, 9'd2, 32'h0000_0001, 1'b0},
        '{'{ACT_INSERT, 32'hFFFF_FFFF, 32'h0000_0005, 32'h0000_1000, 4'h3, 8'd0},
          1'b1, STAT_ADDED, 9'd3, 32'h0000_0006, 1'b0},
        '{'{ACT_INSERT, 32'h0000_0000, 32'h0000_0001, 32'h8000_0000, 4'h8, 8'd0},
          1'b1, STAT_ADDED, 9'd4, 32'h0000_0007, 1'b0},
        '{'{ACT_INSERT, 32'h0000_0000, 32'h0000_0001, 32'h0000_0001, 4'h9, 8'd0},
          1'b1, STAT_DUP, 9'd4, 32'h0000_0007, 1'b0},
        '{'{ACT_READ,   32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 4'h0, 8'd0},
          1'b0, STAT_READ_OK, 9'd0, 32'h0000_0000, 1'b0},
        '{'{ACT_READ,   32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 4'h0, 8'd1},
          1'b0, STAT_READ_OK, 9'd0, 32'h0000_0000, 1'b0},
        '{'{ACT_READ,   32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 4'h0, 8'd2},
          1'b0, STAT_READ_OK, 9'd0, 32'h0000_0000, 1'b0},
        '{'{ACT_READ,   32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 4'h0, 8'd3},
          1'b0, STAT_READ_OK, 9'd0, 32'h0000_0000, 1'b0},
        '{'{ACT_READ,   32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 4'h0, 8'd4},
          1'b1, STAT_RANK_BAD, 9'd4, 32'h0000_0007, 1'b0},
        '{'{ACT_READ,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hF, 8'd255},
          1'b1, STAT_RANK_BAD, 9'd4, 32'h0000_0007, 1'b0},
        '{'{ACT_NONE,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hF, 8'd255},
          1'b1, STAT_IGNORED, 9'd4, 32'h0000_0007, 1'b0},
        '{'{ACT_INSERT, 32'h0000_0000, 32'h0000_0002, 32'h0000_0000, 4'h1, 8'd0},
          1'b1, STAT_CONFLICT, 9'd4, 32'h0000_0007, 1'b1},
        '{'{ACT_INSERT, 32'h0000_0042, 32'h0000_0009, 32'h0000_0000, 4'h2, 8'd0},
          1'b1, STAT_IGNORED, 9'd4, 32'h0000_0007, 1'b1},
        '{'{ACT_INSERT, 32'h0000_0001, 32'h0000_0000, 32'h0000_0000, 4'h2, 8'd0},
          1'b1, STAT_IGNORED, 9'd4, 32'h0000_0007, 1'b1},
        '{'{ACT_READ,   32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 4'h0, 8'd3},
          1'b0, STAT_READ_OK, 9'd0, 32'h0000_0000, 1'b0},
        '{'{ACT_CLEAR,  32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 4'h0, 8'd0},
          1'b1, STAT_CLEARED, 9'd0, 32'h0000_0000, 1'b0},
        '{'{ACT_INSERT, 32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_5555, 4'hA, 8'hAA},
          1'b1, STAT_ADDED, 9'd1, 32'h5555_5555, 1'b0},
        '{'{ACT_INSERT, 32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 4'h5, 8'h55},
          1'b1, STAT_ADDED, 9'd2, 32'hFFFF_FFFF, 1'b0},
        '{'{ACT_READ,   32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 4'h0, 8'd0},
          1'b0, STAT_READ_OK, 9'd0, 32'h0000_0000, 1'b0},
        '{'{ACT_READ,   32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 4'h0, 8'd1},
          1'b0, STAT_READ_OK, 9'd0, 32'h0000_0000, 1'b0},
        '{'{ACT_CLEAR,  32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 4'h0, 8'd0},
          1'b1, STAT_CLEARED, 9'd0, 32'h0000_0000, 1'b0}
    };

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_ready;
    logic [1:0]        i_action = '0;
    logic [WORD_W-1:0] i_entry_key = '0;
    logic [WORD_W-1:0] i_entry_size = '0;
    logic [WORD_W-1:0] i_source_offset = '0;
    logic [SRC_W-1:0]  i_source_number = '0;
    logic [IDX_W-1:0]  i_read_rank = '0;
    logic              o_valid;
    logic              i_ready = 1'b0;
    logic [3:0]        o_status;
    logic [WORD_W-1:0] o_out_key;
    logic [WORD_W-1:0] o_out_offset;
    logic [WORD_W-1:0] o_out_size;
    logic [SRC_W-1:0]  o_out_source_number;
    logic [WORD_W-1:0] o_out_source_offset;
    logic [CNT_W-1:0]  o_entry_total;
    logic [WORD_W-1:0] o_body_total;
    logic              o_merge_failed;

    t_entry            index_tab [TABLE_DEPTH];
    int                held_n = 0;
    logic [WORD_W-1:0] size_sum = '0;
    logic              merge_bad = 1'b0;
    t_result           pending_q [$];
    t_result           head;
    int                err_cnt = 0;
    int                sent_n = 0;
    int                stall_cnt = 0;
    int                gap_pct = 0;
    bit                calm = 1'b0;

    dedup_sorted_index_builder dut (.*);

    always #1 i_clk = ~i_clk;

    function automatic int find_key(input logic [WORD_W-1:0] key);
        int i;
        int hit;
        hit = -1;
        for (i = 0; i < held_n; i++) begin
            if (hit < 0 && index_tab[i].key == key) begin
                hit = i;
            end
        end
        return hit;
    endfunction

    function automatic t_result index_step(input t_req rq);
        t_result res;
        int      hit;
        int      pos;
        int      i;
        res = '0;
        res.status = STAT_IGNORED;
        case (rq.act)
            ACT_INSERT: begin
                hit = find_key(rq.key);
                if (merge_bad) begin
                    res.status = STAT_IGNORED;
                end else if (rq.size == '0) begin
                    res.status = STAT_ZERO;
                end else if (hit >= 0) begin
                    if (index_tab[hit].size == rq.size) begin
                        res.status = STAT_DUP;
                    end else begin
                        merge_bad = 1'b1;
                        res.status = STAT_CONFLICT;
                    end
                end else if (held_n >= TABLE_DEPTH) begin
                    merge_bad = 1'b1;
                    res.status = STAT_FULL;
                end else begin
                    pos = 0;
                    while (pos < held_n && $signed(index_tab[pos].key) < $signed(rq.key)) begin
                        pos++;
                    end
                    for (i = held_n; i > pos; i--) begin
                        index_tab[i] = index_tab[i-1];
                    end
                    index_tab[pos].key    = rq.key;
                    index_tab[pos].size   = rq.size;
                    index_tab[pos].offset = size_sum;
                    index_tab[pos].snum   = rq.snum;
                    index_tab[pos].soff   = rq.soff;
                    held_n++;
                    size_sum += rq.size;
                    res.status = STAT_ADDED;
                end
            end
            ACT_READ: begin
                if (int'(rq.rank) < held_n) begin
                    res.status = STAT_READ_OK;
                    res.ent = index_tab[rq.rank];
                end else begin
                    res.status = STAT_RANK_BAD;
                end
            end
            ACT_CLEAR: begin
                held_n = 0;
                size_sum = '0;
                merge_bad = 1'b0;
                res.status = STAT_CLEARED;
            end
            default: begin
                res.status = STAT_IGNORED;
            end
        endcase
        res.count = CNT_W'(held_n);
        res.body = size_sum;
        res.failed = merge_bad;
        return res;
    endfunction

    function automatic logic [WORD_W-1:0] pick_key();
        logic [WORD_W-1:0] k;
        k = $urandom();
        case ($urandom_range(0, 7))
            0: k = SIGN_FLIP + $urandom_range(0, 3);
            1: k = ~SIGN_FLIP - $urandom_range(0, 3);
            2: k = $urandom_range(0, 3) - 2;
            default: ;
        endcase
        return k;
    endfunction

    function automatic logic [WORD_W-1:0] pick_size();
        logic [WORD_W-1:0] s;
        case ($urandom_range(0, 9))
            0: s = '0;
            1: s = $urandom();
            2: s = 32'hFFFF_FFFF - $urandom_range(0, 255);
            default: s = $urandom_range(1, 4096);
        endcase
        return s;
    endfunction

    function automatic void check_field(input string name, input logic [WORD_W-1:0] want,
                                        input logic [WORD_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            err_cnt++;
        end
    endfunction

    task automatic send_item(input t_req rq, input bit typed, input t_result typed_res);
        t_result pred;
        if (!calm && gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_action        <= rq.act;
        i_entry_key     <= rq.key;
        i_entry_size    <= rq.size;
        i_source_offset <= rq.soff;
        i_source_number <= rq.snum;
        i_read_rank     <= rq.rank;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        pred = index_step(rq);
        pending_q.push_back(typed ? typed_res : pred);
        sent_n++;
        if (sent_n >= CALM_FROM) begin
            calm = 1'b1;
        end
    endtask

    task automatic wait_all_done();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_q.size() != 0);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_q.size() == 0) begin
                $display("%0t: result with no transaction pending, expected none, actual status %0d",
                         $time, o_status);
                err_cnt++;
            end else begin
                head = pending_q.pop_front();
                check_field("status", head.status, o_status);
                check_field("out_key", head.ent.key, o_out_key);
                check_field("out_offset", head.ent.offset, o_out_offset);
                check_field("out_size", head.ent.size, o_out_size);
                check_field("out_source_number", head.ent.snum, o_out_source_number);
                check_field("out_source_offset", head.ent.soff, o_out_source_offset);
                check_field("entry_total", head.count, o_entry_total);
                check_field("body_total", head.body, o_body_total);
                check_field("merge_failed", head.failed, o_merge_failed);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            stall_cnt <= 0;
        end else begin
            stall_cnt <= stall_cnt + 1;
        end
        if (stall_cnt >= STALL_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        @(posedge i_clk);
        forever begin
            if (!calm && $urandom_range(0, 2) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge i_clk);
        end
    end

    initial begin
        t_req    rq;
        t_result typed_res;
        int      r;
        int      n;
        int      seq_len;
        int      pick;
        int      hit;
        bit      keep_going;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        gap_pct = 25;
        for (r = 0; r < NUM_DIRECTED; r++) begin
            typed_res = '0;
            typed_res.status = DIRECTED_ROWS[r].st;
            typed_res.count  = DIRECTED_ROWS[r].cnt;
            typed_res.body   = DIRECTED_ROWS[r].body;
            typed_res.failed = DIRECTED_ROWS[r].bad;
            send_item(DIRECTED_ROWS[r].req, DIRECTED_ROWS[r].typed, typed_res);
        end
        wait_all_done();

        // Fill the table to depth, then push one duplicate and one new key past it, with reads.
        rq = '0;
        rq.act = ACT_CLEAR;
        send_item(rq, 1'b0, '0);
        for (n = 0; n < TABLE_DEPTH; n++) begin
            rq.act = ACT_INSERT;
            do rq.key = $urandom(); while (find_key(rq.key) >= 0);
            do rq.size = $urandom(); while (rq.size == '0);
            rq.soff = $urandom();
            rq.snum = SRC_W'($urandom());
            rq.rank = IDX_W'($urandom());
            send_item(rq, 1'b0, '0);
        end
        hit = $urandom_range(0, TABLE_DEPTH - 1);
        rq.key = index_tab[hit].key;
        rq.size = index_tab[hit].size;
        send_item(rq, 1'b0, '0);
        rq.act = ACT_READ;
        rq.rank = IDX_W'(TABLE_DEPTH - 1);
        send_item(rq, 1'b0, '0);
        rq.act = ACT_INSERT;
        do rq.key = $urandom(); while (find_key(rq.key) >= 0);
        send_item(rq, 1'b0, '0);
        rq.act = ACT_READ;
        rq.rank = IDX_W'($urandom());
        send_item(rq, 1'b0, '0);
        wait_all_done();

        while (sent_n < ITEM_GOAL) begin
            gap_pct = $urandom_range(0, 1) ? 0 : 30;
            rq = '0;
            rq.act = ACT_CLEAR;
            send_item(rq, 1'b0, '0);
            seq_len = $urandom_range(8, 50);
            keep_going = 1'b1;
            for (n = 0; n < seq_len && keep_going && sent_n < ITEM_GOAL; n++) begin
                rq.key  = $urandom();
                rq.size = $urandom();
                rq.soff = $urandom();
                rq.snum = SRC_W'($urandom());
                rq.rank = IDX_W'($urandom());
                pick = $urandom_range(0, 99);
                hit = (held_n > 0) ? $urandom_range(0, held_n - 1) : 0;
                if (pick < 55) begin
                    rq.act  = ACT_INSERT;
                    rq.key  = pick_key();
                    rq.size = pick_size();
                end else if (pick < 67 && held_n > 0) begin
                    rq.act  = ACT_INSERT;
                    rq.key  = index_tab[hit].key;
                    rq.size = index_tab[hit].size;
                end else if (pick < 69 && held_n > 0) begin
                    rq.act  = ACT_INSERT;
                    rq.key  = index_tab[hit].key;
                    rq.size = index_tab[hit].size + 1;
                    if (rq.size == '0) begin
                        rq.size = 2;
                    end
                end else if (pick < 92) begin
                    rq.act = ACT_READ;
                    if (held_n > 0 && $urandom_range(0, 4) != 0) begin
                        rq.rank = IDX_W'($urandom_range(0, held_n - 1));
                    end
                end else if (pick < 96) begin
                    rq.act = ACT_NONE;
                end else begin
                    rq.act = ACT_CLEAR;
                end
                send_item(rq, 1'b0, '0);
                if (merge_bad && $urandom_range(0, 2) == 0) begin
                    keep_going = 1'b0;
                end
            end
        end

        wait_all_done();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
